>>> rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and SHA-256 functions for the stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  typedef logic [31:0] word_t;

  // Input item kinds carried on in_tuser
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_LEN  = 5'b00100,
    ST_COMP = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic shift_byte;
    logic start;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic word_t ror(input word_t v, input int unsigned n);
    logic [63:0] dbl;
    dbl = {v, v} >> n;
    return dbl[31:0];
  endfunction

  function automatic word_t bsig0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t r;
    case (i)
      6'd0:  r = 32'h428a2f98;
      6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;
      6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;
      6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;
      6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;
      6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;
      6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;
      6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;
      6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;
      6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;
      6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;
      6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;
      6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;
      6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;
      6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;
      6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;
      6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;
      6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;
      6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;
      6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;
      6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;
      6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// Block window and iterative compression unit: one SHA-256 round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_core
  import shs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  core_ctl_t        ctl,
  input  logic [7:0]       byte_in,
  input  logic [7:0][31:0] chain_in,
  output logic [7:0][31:0] vars_out,
  output core_stat_t       stat
);

  // win_r holds the 16-word schedule window, oldest word in the top bits
  logic [511:0]     win_r, win_nxt;
  logic [7:0][31:0] var_r, var_nxt;
  logic [5:0]       round_r, round_nxt;
  logic             running_r, running_nxt;
  logic             done_r, done_nxt;

  word_t w0, w1, w9, w14, w_new, t1, t2, maj, ch;

  always_comb begin
    w0    = win_r[511:480];
    w1    = win_r[479:448];
    w9    = win_r[223:192];
    w14   = win_r[63:32];
    w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
    ch    = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    maj   = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    t1    = var_r[7] + bsig1(var_r[4]) + ch + round_k(round_r) + w0;
    t2    = bsig0(var_r[0]) + maj;
  end

  always_comb begin
    win_nxt     = win_r;
    var_nxt     = var_r;
    round_nxt   = round_r;
    running_nxt = running_r;
    done_nxt    = 1'b0;
    if (ctl.shift_byte) begin
      win_nxt = {win_r[503:0], byte_in};
    end
    if (ctl.start) begin
      var_nxt     = chain_in;
      round_nxt   = '0;
      running_nxt = 1'b1;
    end else if (running_r) begin
      win_nxt    = {win_r[479:0], w_new};
      var_nxt[7] = var_r[6];
      var_nxt[6] = var_r[5];
      var_nxt[5] = var_r[4];
      var_nxt[4] = var_r[3] + t1;
      var_nxt[3] = var_r[2];
      var_nxt[2] = var_r[1];
      var_nxt[1] = var_r[0];
      var_nxt[0] = t1 + t2;
      round_nxt  = round_r + 6'd1;
      if (round_r == ROUND_LAST) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    var_r <= var_nxt;
    if (!rst_n) begin
      round_r   <= '0;
      running_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      round_r   <= round_nxt;
      running_r <= running_nxt;
      done_r    <= done_nxt;
    end
  end

  assign vars_out  = var_r;
  assign stat.busy = running_r;
  assign stat.done = done_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !running_r)
    else $error("compression started while busy");

  a_no_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_byte |-> !running_r)
    else $error("byte shifted into window during rounds");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(running_r) && !running_r))
    else $error("done without a finished round sequence");

  a_round_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (running_r && round_r == ROUND_LAST) |=> (done_r && round_r == '0))
    else $error("round counter did not wrap at end of block");

endmodule

`default_nettype wire

>>> rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream; emits the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// An absorb item (in_tuser = 0) shifts one byte into the block window; the
// 64th byte of a block also starts a 64-round compression: one round per
// cycle in a single shared round unit, and in_tready stays low until it is
// done. A finish item (in_tuser = 1) pads one byte per cycle, pausing while
// a compression runs, up to the end of the block (plus one extra compression
// when 56 or more bytes were pending), runs one or two compressions, then
// presents the digest words, index 0 first, with out_tlast on index 7. The
// next message is accepted once all eight words are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest 0
  output logic        out_tlast   // last_word
);

  state_t           state_r, state_nxt;
  state_t           ret_r, ret_nxt;
  logic [7:0][31:0] chain_r, chain_nxt;
  logic [5:0]       pend_r, pend_nxt;
  logic [63:0]      msg_r, msg_nxt;
  logic [2:0]       idx_r, idx_nxt;

  core_ctl_t        ctl;
  core_stat_t       stat;
  logic [7:0]       byte_mux;
  logic [7:0]       len_byte;
  logic [7:0][31:0] vars;
  logic             in_acc, out_acc;

  shs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .byte_in  (byte_mux),
    .chain_in (chain_r),
    .vars_out (vars),
    .stat     (stat)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {5'd0, idx_r, chain_r[idx_r]};
  assign out_tlast  = (idx_r == WORD_LAST);

  // length bytes go out big-endian
  assign len_byte = msg_r[{~pend_r[2:0], 3'b000} +: 8];

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    chain_nxt      = chain_r;
    pend_nxt       = pend_r;
    msg_nxt        = msg_r;
    idx_nxt        = idx_r;
    ctl.shift_byte = 1'b0;
    ctl.start      = 1'b0;
    byte_mux       = 8'h00;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.shift_byte = 1'b1;
          pend_nxt       = pend_r + 6'd1;
          if (in_tuser == OP_ABSORB) begin
            byte_mux = in_tdata;
            msg_nxt  = msg_r + BYTE_BITS;
            if (pend_r == BLOCK_LAST) begin
              ctl.start = 1'b1;
              ret_nxt   = ST_IDLE;
              state_nxt = ST_COMP;
            end
          end else begin
            byte_mux = PAD_BYTE;
            if (pend_r == BLOCK_LAST) begin
              ctl.start = 1'b1;
              ret_nxt   = ST_PAD;
              state_nxt = ST_COMP;
            end else begin
              state_nxt = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        if (pend_r == LEN_START) begin
          state_nxt = ST_LEN;
        end else begin
          ctl.shift_byte = 1'b1;
          pend_nxt       = pend_r + 6'd1;
          if (pend_r == BLOCK_LAST) begin
            ctl.start = 1'b1;
            ret_nxt   = ST_PAD;
            state_nxt = ST_COMP;
          end
        end
      end
      ST_LEN: begin
        ctl.shift_byte = 1'b1;
        byte_mux       = len_byte;
        pend_nxt       = pend_r + 6'd1;
        if (pend_r == BLOCK_LAST) begin
          ctl.start = 1'b1;
          ret_nxt   = ST_OUT;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (stat.done) begin
          for (int i = 0; i < 8; i++) begin
            chain_nxt[i] = chain_r[i] + vars[i];
          end
          idx_nxt   = '0;
          state_nxt = ret_r;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == WORD_LAST) begin
            for (int i = 0; i < 8; i++) begin
              chain_nxt[i] = init_hash(3'(i));
            end
            msg_nxt   = '0;
            pend_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      pend_r  <= '0;
      msg_r   <= '0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= init_hash(3'(i));
      end
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pend_r  <= pend_nxt;
      msg_r   <= msg_nxt;
      idx_r   <= idx_nxt;
      chain_r <= chain_nxt;
    end
  end

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == ST_COMP))
    else $error("compression finished outside compress state");

  a_len_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEN) |-> (pend_r[5:3] == 3'b111))
    else $error("length bytes outside last eight block bytes");

  a_comp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && !stat.done) |-> stat.busy)
    else $error("compress state with idle round unit");

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sha256_stream_hasher: byte messages of chosen and
// random lengths go in, and each digest word that comes out is compared with
// a SHA-256 computed on the bench side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam bit [31:0] SHA_K [64] = '{
  32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
  32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
  32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
  32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
  32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
  32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
  32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
  32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
  32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
  32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
  32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
  32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
  32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
  32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
  32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
  32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
};

localparam bit [31:0] SHA_IV [8] = '{
  32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
};

typedef struct packed {
  bit [31:0] word;
  bit [2:0]  word_idx;
  bit        is_last;
} digest_word_t;

class digest_scoreboard;
  bit [31:0] chain [8];
  bit [31:0] blk [16];
  bit [5:0]  fill;
  bit [63:0] nbits;
  digest_word_t digest_q [$];
  int errors;
  int checked;
  int items;
  int messages;

  function new();
    errors = 0;
    checked = 0;
    items = 0;
    messages = 0;
    start_message();
  endfunction

  function void start_message();
    foreach (chain[i]) chain[i] = SHA_IV[i];
    fill = '0;
    nbits = '0;
  endfunction

  function bit [31:0] rotr(bit [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void put_byte(bit [5:0] pos, bit [7:0] b);
    int sh;
    sh = 24 - 8 * int'(pos[1:0]);
    if (pos[1:0] == 2'd0) begin
      blk[pos[5:2]] = {24'b0, b} << sh;
    end else begin
      blk[pos[5:2]] |= {24'b0, b} << sh;
    end
  endfunction

  function void compress();
    bit [31:0] w [64];
    bit [31:0] v [8];
    bit [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) w[i] = blk[i];
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    foreach (v[k]) v[k] = chain[k];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    foreach (chain[k]) chain[k] += v[k];
  endfunction

  function void note_item(bit op, bit [7:0] b);
    digest_word_t dw;
    int p;
    items++;
    if (op == shs_pkg::OP_ABSORB) begin
      put_byte(fill, b);
      nbits += 64'd8;
      fill++;
      if (fill == 6'd0) compress();
    end else begin
      put_byte(fill, shs_pkg::PAD_BYTE);
      for (p = int'(fill) + 1; p < 64; p++) put_byte(6'(p), 8'h00);
      // length field does not fit: spill into a second block
      if (fill >= shs_pkg::LEN_START) begin
        compress();
        foreach (blk[k]) blk[k] = '0;
      end
      blk[14] = nbits[63:32];
      blk[15] = nbits[31:0];
      compress();
      for (p = 0; p < 8; p++) begin
        dw.word = chain[p];
        dw.word_idx = 3'(p);
        dw.is_last = (p == 7);
        digest_q.push_back(dw);
      end
      messages++;
      start_message();
    end
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task check_word(logic [39:0] tdata, logic tlast);
    digest_word_t dw;
    if (digest_q.size() == 0) begin
      report($sformatf("digest word %h with none expected", tdata));
      return;
    end
    dw = digest_q.pop_front();
    checked++;
    if (tdata[31:0] !== dw.word)
      report($sformatf("word %0d: got %h, want %h", dw.word_idx, tdata[31:0], dw.word));
    if (tdata[34:32] !== dw.word_idx)
      report($sformatf("word index: got %0d, want %0d", tdata[34:32], dw.word_idx));
    if (tdata[39:35] !== 5'b0)
      report($sformatf("word %0d: nonzero pad bits %b", dw.word_idx, tdata[39:35]));
    if (tlast !== dw.is_last)
      report($sformatf("word %0d: tlast %b, want %b", dw.word_idx, tlast, dw.is_last));
  endtask
endclass

module tb;
  import shs_pkg::*;

  localparam int ITEM_TARGET = 360;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  logic        out_tlast;

  digest_scoreboard sb;
  int tx_idle_pct;
  int rx_stall_pct;
  int quiet;
  int longest_msg;

  sha256_stream_hasher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    sb = new();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    quiet = 0;
    longest_msg = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_ABSORB;
    out_tready <= 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom);
      in_tuser <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(op, b);
  endtask

  task send_message(input int len);
    int i;
    for (i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom));
    send_item(OP_FINISH, 8'($urandom));
    if (len > longest_msg) longest_msg = len;
  endtask

  function int pick_length();
    int sel;
    int edges [6];
    edges = '{55, 56, 57, 63, 64, 65};
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(0, 12);
    if (sel < 80) return edges[$urandom_range(0, 5)];
    return $urandom_range(0, 130);
  endfunction

  initial begin
    int phase;
    int len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, then "abc", then extreme byte values
    send_item(OP_FINISH, 8'hff);
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'h80);
    send_item(OP_ABSORB, 8'h7f);
    send_item(OP_FINISH, 8'h5a);
    send_item(OP_FINISH, 8'ha5);
    if (longest_msg < 4) longest_msg = 4;

    while (sb.items < ITEM_TARGET) begin
      phase = (sb.items * 4) / ITEM_TARGET;
      case (phase)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 45;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 45;
        end
        default: begin
          tx_idle_pct = 19;
          rx_stall_pct = 19;
        end
      endcase
      len = pick_length();
      if (len > ITEM_TARGET - sb.items) len = ITEM_TARGET - sb.items;
      send_message(len);
    end
    in_tvalid <= 1'b0;

    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d input items, longest %0d bytes,",
             sb.messages, sb.items, longest_msg);
    $display("across idle and stall phases; %0d digest words compared.", sb.checked);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/shs_pkg.sv
rtl/shs_core.sv
rtl/sha256_stream_hasher.sv
test/tb.sv
